>>> rtl/core/u8d_pkg.sv
// shared types and constants for the utf-8 stream decoder
// no dependencies; used by the channel interfaces and the top level
package u8d_pkg;

    localparam int BYTE_W  = 8;
    localparam int POINT_W = 21;
    localparam int OWED_W  = 2;
    localparam int STAT_W  = 2;

    typedef enum logic [STAT_W-1:0] {
        STATUS_OK      = 2'd0,
        STATUS_INVALID = 2'd1,
        STATUS_TRUNC   = 2'd2
    } status_t;

endpackage

>>> rtl/core/u8d_if.sv
// valid/ready channel interfaces for the utf-8 stream decoder
// depends on u8d_pkg for field widths
interface u8d_byte_if;
    import u8d_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              stream_end;

    modport source (output valid, output in_byte, output stream_end, input ready);
    modport sink   (input valid, input in_byte, input stream_end, output ready);
endinterface

interface u8d_point_if;
    import u8d_pkg::*;

    logic               valid;
    logic               ready;
    logic [POINT_W-1:0] codepoint;
    logic [STAT_W-1:0]  status;

    modport source (output valid, output codepoint, output status, input ready);
    modport sink   (input valid, input codepoint, input status, output ready);
endinterface

>>> rtl/core/utf8_stream_decoder.sv
// utf-8 stream decoder: one byte per request in, zero or one codepoint result out
// path: an accepted byte waits in the input register and is decoded into the
//   result register once that is empty or being taken; throughput one byte per
//   cycle unless a held result stalls, via the single decode step between registers
// reset (rst_n low, async) clears both valid flags and the partial sequence
// depends on u8d_pkg and the channel interfaces in u8d_if.sv
module utf8_stream_decoder (
    input  logic              clk,
    input  logic              rst_n,
    u8d_byte_if.sink          byte_ch,
    u8d_point_if.source       point_ch
);
    import u8d_pkg::*;

    // input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              end_reg;

    // decoder state
    logic [POINT_W-1:0] partial_reg, partial_next;
    logic [OWED_W-1:0]  owed_reg, owed_next;

    // result register
    logic               out_valid_reg;
    logic [POINT_W-1:0] point_reg, point_next;
    status_t            status_reg, status_next;
    logic               emit_next;

    logic               advance;
    logic [POINT_W-1:0] shifted;
    logic [OWED_W-1:0]  owed_dec;

    assign advance       = in_valid_reg && (!out_valid_reg || point_ch.ready);
    assign byte_ch.ready = !in_valid_reg || advance;

    assign point_ch.valid     = out_valid_reg;
    assign point_ch.codepoint = point_reg;
    assign point_ch.status    = status_reg;

    assign shifted  = {partial_reg[POINT_W-7:0], byte_reg[5:0]};
    assign owed_dec = owed_reg - OWED_W'(1);

    always_comb
    begin
        partial_next = partial_reg;
        owed_next    = owed_reg;
        emit_next    = 1'b0;
        point_next   = '0;
        status_next  = STATUS_OK;

        if (owed_reg == '0)
        begin
            if (byte_reg[7] == 1'b0)
            begin
                emit_next  = 1'b1;
                point_next = POINT_W'(byte_reg);
            end
            else if (byte_reg[7:5] == 3'b110)
            begin
                partial_next = POINT_W'(byte_reg[4:0]);
                owed_next    = OWED_W'(1);
            end
            else if (byte_reg[7:4] == 4'b1110)
            begin
                partial_next = POINT_W'(byte_reg[3:0]);
                owed_next    = OWED_W'(2);
            end
            else if (byte_reg[7:3] == 5'b11110)
            begin
                partial_next = POINT_W'(byte_reg[2:0]);
                owed_next    = OWED_W'(3);
            end
            else
            begin
                // stray continuation or out-of-range lead
                emit_next    = 1'b1;
                status_next  = STATUS_INVALID;
                partial_next = '0;
                owed_next    = '0;
            end
        end
        else if (byte_reg[7:6] != 2'b10)
        begin
            // bad continuation is consumed, not reread as a lead
            emit_next    = 1'b1;
            status_next  = STATUS_INVALID;
            partial_next = '0;
            owed_next    = '0;
        end
        else if (owed_dec == '0)
        begin
            emit_next    = 1'b1;
            point_next   = shifted;
            partial_next = '0;
            owed_next    = '0;
        end
        else
        begin
            partial_next = shifted;
            owed_next    = owed_dec;
        end

        // truncation only when this byte left the sequence open
        if (!emit_next && end_reg && owed_next != '0)
        begin
            emit_next    = 1'b1;
            status_next  = STATUS_TRUNC;
            partial_next = '0;
            owed_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            partial_reg   <= '0;
            owed_reg      <= '0;
        end
        else
        begin
            if (byte_ch.ready)
            begin
                in_valid_reg <= byte_ch.valid;
            end

            if (advance)
            begin
                out_valid_reg <= emit_next;
                partial_reg   <= partial_next;
                owed_reg      <= owed_next;
            end
            else if (point_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_ch.valid && byte_ch.ready)
        begin
            byte_reg <= byte_ch.in_byte;
            end_reg  <= byte_ch.stream_end;
        end

        if (advance && emit_next)
        begin
            point_reg  <= point_next;
            status_reg <= status_next;
        end
    end

endmodule
